### rtl/buffer_pool_message_queue_unit_defines.svh
// Assertion macros for the buffer pool message queue unit.
// Included by the RTL files that carry concurrent assertions; needs clock and reset in scope.
`ifndef BUFFER_POOL_MESSAGE_QUEUE_UNIT_DEFINES_SVH
`define BUFFER_POOL_MESSAGE_QUEUE_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define BPMQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define BPMQ_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/bpmq_pkg.sv
// Shared types and constants of the buffer pool message queue unit.
// No dependencies; imported by buffer_pool_message_queue_unit and its testbench.
`default_nettype none

package bpmq_pkg;

   localparam int POOL_BUFFERS = 64;
   localparam int COUNT_BITS = 32;
   localparam int BUF_BITS = $clog2(POOL_BUFFERS);
   localparam int CNT_W = $clog2(POOL_BUFFERS + 1);
   localparam int KIND_BITS = 3;
   localparam int STATUS_BITS = 2;
   localparam int BSTATE_BITS = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 7;

   localparam logic [CNT_W-1:0] POOL_COUNT = CNT_W'(POOL_BUFFERS);
   localparam logic [CNT_W-1:0] RESET_BUFFERS = CNT_W'(16);

   localparam logic [KIND_BITS-1:0] KIND_ALLOC = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_SEND = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_RECV = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_FREE = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_PURGE = 3'd4;

   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_BUFFER = 2'd3;

   localparam logic [BSTATE_BITS-1:0] BST_UNUSED = 2'd0;
   localparam logic [BSTATE_BITS-1:0] BST_FREE = 2'd1;
   localparam logic [BSTATE_BITS-1:0] BST_READY = 2'd2;
   localparam logic [BSTATE_BITS-1:0] BST_USER = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_BUFFERS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALLOW_GROWTH = 2'd1;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } bpmq_state_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [BUF_BITS-1:0]  buffer;
   } bpmq_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [BUF_BITS-1:0]    granted_buffer;
      logic [CNT_W-1:0]       ready_count;
      logic [CNT_W-1:0]       free_count;
      logic [CNT_W-1:0]       user_count;
      logic [CNT_W-1:0]       pool_in_use;
      logic [COUNT_BITS-1:0]  total_sends;
      logic [COUNT_BITS-1:0]  total_receives;
      logic [CNT_W-1:0]       peak_ready;
   } bpmq_rsp_type;

endpackage

`default_nettype wire

### rtl/bpmq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module bpmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/buffer_pool_message_queue_unit.sv
// Buffer pool manager with a LIFO free list and a FIFO ready queue; uses bpmq_pkg and bpmq_ram.
// A command is carried out in the execute state, and the result strobe is registered as that
// state is left; the next command may be accepted at the edge that completes the result transfer.
// Purge frees ready buffers one after another in the execute state, paced by the next link read.
// Synchronous reset restores 16 free buffers with growth off at once; no clearing pass.
// The result channel cannot stall.
`default_nettype none
`include "buffer_pool_message_queue_unit_defines.svh"

module buffer_pool_message_queue_unit
   import bpmq_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire bpmq_req_type              req_payload,
   output logic                           rsp_strobe,
   output bpmq_rsp_type                   rsp_payload,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   bpmq_state_type state_ff, state_in;
   bpmq_req_type cmd_ff, cmd_in;
   bpmq_rsp_type rsp_ff, rsp_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   logic allow_growth_ff, allow_growth_in;
   logic [CNT_W-1:0] enabled_ff, enabled_in;
   logic [CNT_W-1:0] ready_cnt_ff, ready_cnt_in;
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0] user_cnt_ff, user_cnt_in;
   logic [CNT_W-1:0] fresh_cnt_ff, fresh_cnt_in;
   logic [CNT_W-1:0] peak_ff, peak_in;
   logic [COUNT_BITS-1:0] sends_ff, sends_in;
   logic [COUNT_BITS-1:0] recvs_ff, recvs_in;
   logic [BUF_BITS-1:0] free_head_ff, free_head_in;
   logic [BUF_BITS-1:0] ready_head_ff, ready_head_in;
   logic [BUF_BITS-1:0] ready_tail_ff, ready_tail_in;
   logic [POOL_BUFFERS-1:0] valid_ff, valid_in;

   logic link_we;
   logic [BUF_BITS-1:0] link_wa, link_wd, link_ra, link_rdata;
   logic bst_we;
   logic [BUF_BITS-1:0] bst_wa, bst_ra;
   logic [BSTATE_BITS-1:0] bst_wd, bst_rdata;

   logic [BSTATE_BITS-1:0] cur_bst;
   logic user_ok;
   logic [CNT_W-1:0] grow_half, grow_room, grow_add, grow_top;
   logic grow_now;
   logic [BUF_BITS-1:0] alloc_head;
   logic [CNT_W-1:0] alloc_free, alloc_fresh;
   logic alloc_fresh_top;
   logic [CNT_W-1:0] ready_inc, csr_buffers;
   logic [STATUS_BITS-1:0] status;
   logic [BUF_BITS-1:0] granted;
   logic done;

   bpmq_ram #(.WIDTH(BUF_BITS), .DEPTH(POOL_BUFFERS)) link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (link_ra),
      .rd_data (link_rdata)
   );

   bpmq_ram #(.WIDTH(BSTATE_BITS), .DEPTH(POOL_BUFFERS)) state_ram (
      .clock   (clock),
      .wr_en   (bst_we),
      .wr_addr (bst_wa),
      .wr_data (bst_wd),
      .rd_addr (bst_ra),
      .rd_data (bst_rdata)
   );

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // Buffers never written since the pool was set up read as free if enabled, else unused.
   assign cur_bst = valid_ff[cmd_ff.buffer] ? bst_rdata :
                    (({1'b0, cmd_ff.buffer} < enabled_ff) ? BST_FREE : BST_UNUSED);
   assign user_ok = ({1'b0, cmd_ff.buffer} < enabled_ff) && (cur_bst == BST_USER);

   assign grow_half = enabled_ff >> 1;
   assign grow_room = POOL_COUNT - enabled_ff;
   assign grow_add = (grow_half > grow_room) ? grow_room : grow_half;
   assign grow_top = enabled_ff + grow_add - CNT_W'(1);
   assign grow_now = (free_cnt_ff == '0);

   // Untouched buffers sit at the bottom of the free list, chained downward by index.
   assign alloc_head = grow_now ? grow_top[BUF_BITS-1:0] : free_head_ff;
   assign alloc_free = grow_now ? grow_add : free_cnt_ff;
   assign alloc_fresh = grow_now ? grow_add : fresh_cnt_ff;
   assign alloc_fresh_top = (alloc_fresh != '0) && (alloc_fresh == alloc_free);

   assign ready_inc = ready_cnt_ff + CNT_W'(1);

   always_comb begin
      csr_buffers = csr_data[CNT_W-1:0];
      if (csr_buffers == '0) begin
         csr_buffers = CNT_W'(1);
      end else if (csr_buffers > POOL_COUNT) begin
         csr_buffers = POOL_COUNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         allow_growth_ff <= 1'b0;
         enabled_ff <= RESET_BUFFERS;
         ready_cnt_ff <= '0;
         free_cnt_ff <= RESET_BUFFERS;
         user_cnt_ff <= '0;
         fresh_cnt_ff <= RESET_BUFFERS;
         peak_ff <= '0;
         sends_ff <= '0;
         recvs_ff <= '0;
         free_head_ff <= BUF_BITS'(RESET_BUFFERS - CNT_W'(1));
         ready_head_ff <= '0;
         ready_tail_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         allow_growth_ff <= allow_growth_in;
         enabled_ff <= enabled_in;
         ready_cnt_ff <= ready_cnt_in;
         free_cnt_ff <= free_cnt_in;
         user_cnt_ff <= user_cnt_in;
         fresh_cnt_ff <= fresh_cnt_in;
         peak_ff <= peak_in;
         sends_ff <= sends_in;
         recvs_ff <= recvs_in;
         free_head_ff <= free_head_in;
         ready_head_ff <= ready_head_in;
         ready_tail_ff <= ready_tail_in;
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      rsp_in = rsp_ff;
      rsp_strobe_in = 1'b0;
      allow_growth_in = allow_growth_ff;
      enabled_in = enabled_ff;
      ready_cnt_in = ready_cnt_ff;
      free_cnt_in = free_cnt_ff;
      user_cnt_in = user_cnt_ff;
      fresh_cnt_in = fresh_cnt_ff;
      peak_in = peak_ff;
      sends_in = sends_ff;
      recvs_in = recvs_ff;
      free_head_in = free_head_ff;
      ready_head_in = ready_head_ff;
      ready_tail_in = ready_tail_ff;
      valid_in = valid_ff;
      link_we = 1'b0;
      link_wa = ready_head_ff;
      link_wd = free_head_ff;
      link_ra = free_head_ff;
      bst_we = 1'b0;
      bst_wa = cmd_ff.buffer;
      bst_wd = BST_USER;
      bst_ra = req_payload.buffer;
      status = STATUS_OK;
      granted = '0;
      done = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_payload;
               link_ra = (req_payload.kind == KIND_ALLOC) ? free_head_ff : ready_head_ff;
               state_in = S_EXEC;
            end else if (csr_valid) begin
               if (csr_index == CSR_INITIAL_BUFFERS) begin
                  valid_in = '0;
                  enabled_in = csr_buffers;
                  free_cnt_in = csr_buffers;
                  fresh_cnt_in = csr_buffers;
                  free_head_in = BUF_BITS'(csr_buffers - CNT_W'(1));
                  ready_cnt_in = '0;
                  user_cnt_in = '0;
                  peak_in = '0;
                  sends_in = '0;
                  recvs_in = '0;
                  ready_head_in = '0;
                  ready_tail_in = '0;
               end else if (csr_index == CSR_ALLOW_GROWTH) begin
                  allow_growth_in = csr_data[0];
               end
            end
         end
         S_EXEC: begin
            done = 1'b1;
            unique case (cmd_ff.kind)
               KIND_ALLOC: begin
                  if (grow_now && (!allow_growth_ff || (grow_add == '0))) begin
                     status = STATUS_NO_FREE;
                  end else begin
                     if (grow_now) begin
                        enabled_in = enabled_ff + grow_add;
                     end
                     granted = alloc_head;
                     free_head_in = alloc_fresh_top ? (alloc_head - BUF_BITS'(1)) : link_rdata;
                     fresh_cnt_in = alloc_fresh_top ? (alloc_fresh - CNT_W'(1)) : alloc_fresh;
                     free_cnt_in = alloc_free - CNT_W'(1);
                     user_cnt_in = user_cnt_ff + CNT_W'(1);
                     bst_we = 1'b1;
                     bst_wa = alloc_head;
                     bst_wd = BST_USER;
                     valid_in[alloc_head] = 1'b1;
                  end
               end
               KIND_SEND: begin
                  if (!user_ok) begin
                     status = STATUS_BAD_BUFFER;
                  end else begin
                     if (ready_cnt_ff == '0) begin
                        ready_head_in = cmd_ff.buffer;
                     end else begin
                        link_we = 1'b1;
                        link_wa = ready_tail_ff;
                        link_wd = cmd_ff.buffer;
                     end
                     ready_tail_in = cmd_ff.buffer;
                     bst_we = 1'b1;
                     bst_wa = cmd_ff.buffer;
                     bst_wd = BST_READY;
                     valid_in[cmd_ff.buffer] = 1'b1;
                     ready_cnt_in = ready_inc;
                     user_cnt_in = user_cnt_ff - CNT_W'(1);
                     sends_in = sends_ff + COUNT_BITS'(1);
                     if (ready_inc > peak_ff) begin
                        peak_in = ready_inc;
                     end
                  end
               end
               KIND_RECV: begin
                  if (ready_cnt_ff == '0) begin
                     status = STATUS_EMPTY;
                  end else begin
                     granted = ready_head_ff;
                     bst_we = 1'b1;
                     bst_wa = ready_head_ff;
                     bst_wd = BST_USER;
                     valid_in[ready_head_ff] = 1'b1;
                     ready_head_in = link_rdata;
                     ready_cnt_in = ready_cnt_ff - CNT_W'(1);
                     if (ready_cnt_ff == CNT_W'(1)) begin
                        ready_head_in = '0;
                        ready_tail_in = '0;
                     end
                     user_cnt_in = user_cnt_ff + CNT_W'(1);
                     recvs_in = recvs_ff + COUNT_BITS'(1);
                  end
               end
               KIND_FREE: begin
                  if (!user_ok) begin
                     status = STATUS_BAD_BUFFER;
                  end else begin
                     link_we = 1'b1;
                     link_wa = cmd_ff.buffer;
                     link_wd = free_head_ff;
                     free_head_in = cmd_ff.buffer;
                     bst_we = 1'b1;
                     bst_wa = cmd_ff.buffer;
                     bst_wd = BST_FREE;
                     valid_in[cmd_ff.buffer] = 1'b1;
                     free_cnt_in = free_cnt_ff + CNT_W'(1);
                     user_cnt_in = user_cnt_ff - CNT_W'(1);
                  end
               end
               KIND_PURGE: begin
                  if (ready_cnt_ff != '0) begin
                     link_we = 1'b1;
                     link_wa = ready_head_ff;
                     link_wd = free_head_ff;
                     link_ra = link_rdata;
                     free_head_in = ready_head_ff;
                     bst_we = 1'b1;
                     bst_wa = ready_head_ff;
                     bst_wd = BST_FREE;
                     valid_in[ready_head_ff] = 1'b1;
                     ready_head_in = link_rdata;
                     ready_cnt_in = ready_cnt_ff - CNT_W'(1);
                     free_cnt_in = free_cnt_ff + CNT_W'(1);
                     recvs_in = recvs_ff + COUNT_BITS'(1);
                     if (ready_cnt_ff == CNT_W'(1)) begin
                        ready_head_in = '0;
                        ready_tail_in = '0;
                     end else begin
                        done = 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
            if (done) begin
               state_in = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_in.status = status;
               rsp_in.granted_buffer = granted;
               rsp_in.ready_count = ready_cnt_in;
               rsp_in.free_count = free_cnt_in;
               rsp_in.user_count = user_cnt_in;
               rsp_in.pool_in_use = enabled_in;
               rsp_in.total_sends = sends_in;
               rsp_in.total_receives = recvs_in;
               rsp_in.peak_ready = peak_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `BPMQ_ASSERT_ALWAYS(a_accounting, (ready_cnt_ff + free_cnt_ff + user_cnt_ff) == enabled_ff, "buffer counts do not add up to the enabled pool")
   `BPMQ_ASSERT_ALWAYS(a_fresh_bound, fresh_cnt_ff <= free_cnt_ff, "untouched buffers exceed the free list length")
   `BPMQ_ASSERT_ALWAYS(a_peak_bound, peak_ff >= ready_cnt_ff, "peak ready length below the current queue length")
   `BPMQ_ASSERT_IMPLY(a_empty_queue, ready_cnt_ff == '0, (ready_head_ff == '0) && (ready_tail_ff == '0), "empty ready queue left stale head or tail")
   `BPMQ_ASSERT_IMPLY(a_rsp_after_exec, rsp_strobe_ff, $past(state_ff == S_EXEC), "result strobe without a preceding execute cycle")

endmodule

`default_nettype wire

### test/buffer_pool_message_queue_unit_tb.sv
// Self-checking testbench for buffer_pool_message_queue_unit: directed commands, then random phases.
// Depends on bpmq_pkg and the RTL; an internal model of the pool predicts the results not given in the plan.
module buffer_pool_message_queue_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpmq_pkg::*;

   localparam logic [KIND_BITS-1:0] KIND_SPARE_LOW = 3'd5;
   localparam logic [KIND_BITS-1:0] KIND_SPARE_MID = 3'd6;
   localparam logic [KIND_BITS-1:0] KIND_SPARE_TOP = 3'd7;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int MAX_GAP = 16;

   typedef struct {
      bit                         is_write;
      logic [CSR_INDEX_BITS-1:0]  index;
      logic [CSR_DATA_BITS-1:0]   data;
      bpmq_req_type               cmd;
      bit                         typed;
      bpmq_rsp_type               want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   bpmq_req_type req_payload = '0;
   logic rsp_strobe;
   bpmq_rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   bpmq_rsp_type expected_results [$];
   int errors = 0;
   int stall_cycles = 0;

   logic [BSTATE_BITS-1:0] pool_state [POOL_BUFFERS];
   logic [BUF_BITS-1:0]    pool_link [POOL_BUFFERS];
   int unsigned free_top, queue_first, queue_last, enabled_total, start_buffers;
   logic growth_on;
   logic [COUNT_BITS-1:0] ready_total, free_total, held_total;
   logic [COUNT_BITS-1:0] send_total, recv_total, peak_total;

   buffer_pool_message_queue_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   function automatic void pool_enable(int unsigned first, int unsigned n);
      int unsigned idx;
      for (int unsigned i = 0; i < n; i++) begin
         idx = first + i;
         if (idx >= POOL_BUFFERS) break;
         pool_link[idx] = (i == 0) ? '0 : BUF_BITS'(idx - 1);
         pool_state[idx] = BST_FREE;
      end
      free_top = first + n - 1;
      enabled_total = first + n;
      free_total = n;
   endfunction

   function automatic void pool_init();
      for (int i = 0; i < POOL_BUFFERS; i++) begin
         pool_link[i] = '0;
         pool_state[i] = BST_UNUSED;
      end
      ready_total = '0;
      free_total = '0;
      held_total = '0;
      send_total = '0;
      recv_total = '0;
      peak_total = '0;
      queue_first = 0;
      queue_last = 0;
      pool_enable(0, start_buffers);
   endfunction

   function automatic void pool_write_register(logic [CSR_INDEX_BITS-1:0] index,
                                               logic [CSR_DATA_BITS-1:0] data);
      int unsigned v;
      v = data;
      if (index == CSR_INITIAL_BUFFERS) begin
         if (v < 1) v = 1;
         if (v > POOL_BUFFERS) v = POOL_BUFFERS;
         start_buffers = v;
         pool_init();
      end else if (index == CSR_ALLOW_GROWTH) begin
         growth_on = data[0];
      end
   endfunction

   function automatic bit held_ok(int unsigned b);
      return b < enabled_total && pool_state[b] == BST_USER;
   endfunction

   function automatic void free_push(int unsigned b);
      pool_link[b] = (free_total != 0) ? BUF_BITS'(free_top) : '0;
      free_top = b;
      pool_state[b] = BST_FREE;
      free_total++;
   endfunction

   function automatic int unsigned ready_pop();
      int unsigned b;
      b = queue_first;
      pool_state[b] = BST_USER;
      queue_first = pool_link[b];
      ready_total--;
      if (ready_total == 0) begin
         queue_first = 0;
         queue_last = 0;
      end
      held_total++;
      recv_total++;
      return b;
   endfunction

   function automatic bpmq_rsp_type pool_apply_command(bpmq_req_type cmd);
      bpmq_rsp_type r;
      logic [STATUS_BITS-1:0] status;
      int unsigned granted, add, b;
      status = STATUS_OK;
      granted = 0;
      case (cmd.kind)
         KIND_ALLOC: begin
            if (free_total == 0) begin
               add = enabled_total / 2;
               if (add > POOL_BUFFERS - enabled_total) add = POOL_BUFFERS - enabled_total;
               if (!growth_on || add == 0) status = STATUS_NO_FREE;
               else pool_enable(enabled_total, add);
            end
            if (status == STATUS_OK) begin
               granted = free_top;
               free_top = pool_link[granted];
               pool_state[granted] = BST_USER;
               pool_link[granted] = '0;
               free_total--;
               held_total++;
            end
         end
         KIND_SEND: begin
            if (!held_ok(cmd.buffer)) begin
               status = STATUS_BAD_BUFFER;
            end else begin
               if (ready_total == 0) queue_first = cmd.buffer;
               else pool_link[queue_last] = cmd.buffer;
               queue_last = cmd.buffer;
               pool_state[cmd.buffer] = BST_READY;
               ready_total++;
               held_total--;
               send_total++;
               if (ready_total > peak_total) peak_total = ready_total;
            end
         end
         KIND_RECV: begin
            if (ready_total == 0) status = STATUS_EMPTY;
            else granted = ready_pop();
         end
         KIND_FREE: begin
            if (!held_ok(cmd.buffer)) begin
               status = STATUS_BAD_BUFFER;
            end else begin
               free_push(cmd.buffer);
               held_total--;
            end
         end
         KIND_PURGE: begin
            while (ready_total != 0) begin
               b = ready_pop();
               free_push(b);
               held_total--;
            end
         end
         default: ;
      endcase
      r.status = status;
      r.granted_buffer = BUF_BITS'(granted);
      r.ready_count = CNT_W'(ready_total);
      r.free_count = CNT_W'(free_total);
      r.user_count = CNT_W'(held_total);
      r.pool_in_use = CNT_W'(enabled_total);
      r.total_sends = send_total;
      r.total_receives = recv_total;
      r.peak_ready = CNT_W'(peak_total);
      return r;
   endfunction

   function automatic int unsigned random_held_buffer();
      int unsigned n, k;
      n = 0;
      for (int i = 0; i < POOL_BUFFERS; i++)
         if (pool_state[i] == BST_USER) n++;
      k = $urandom_range(n - 1);
      for (int i = 0; i < POOL_BUFFERS; i++) begin
         if (pool_state[i] == BST_USER) begin
            if (k == 0) return i;
            k--;
         end
      end
      return 0;
   endfunction

   function automatic bpmq_req_type random_command();
      bpmq_req_type c;
      int unsigned roll;
      roll = $urandom_range(99);
      c.buffer = BUF_BITS'($urandom_range(POOL_BUFFERS - 1));
      if (roll < 30) c.kind = KIND_ALLOC;
      else if (roll < 55) c.kind = KIND_SEND;
      else if (roll < 75) c.kind = KIND_RECV;
      else if (roll < 90) c.kind = KIND_FREE;
      else if (roll < 96) c.kind = KIND_PURGE;
      else c.kind = KIND_BITS'($urandom_range(7));
      if ((c.kind == KIND_SEND || c.kind == KIND_FREE) && held_total != 0 &&
          $urandom_range(99) < 85)
         c.buffer = BUF_BITS'(random_held_buffer());
      return c;
   endfunction

   function automatic bpmq_rsp_type rsp(int status, int granted, int ready, int free_n,
                                        int user, int pool, int sends, int recvs, int peak);
      bpmq_rsp_type r;
      r.status = STATUS_BITS'(status);
      r.granted_buffer = BUF_BITS'(granted);
      r.ready_count = CNT_W'(ready);
      r.free_count = CNT_W'(free_n);
      r.user_count = CNT_W'(user);
      r.pool_in_use = CNT_W'(pool);
      r.total_sends = COUNT_BITS'(sends);
      r.total_receives = COUNT_BITS'(recvs);
      r.peak_ready = CNT_W'(peak);
      return r;
   endfunction

   function automatic plan_row_type cmd_row(logic [KIND_BITS-1:0] kind,
                                            logic [BUF_BITS-1:0] buffer,
                                            bit typed = 0, bpmq_rsp_type want = '0);
      plan_row_type p;
      p.is_write = 0;
      p.index = '0;
      p.data = '0;
      p.cmd.kind = kind;
      p.cmd.buffer = buffer;
      p.typed = typed;
      p.want = want;
      return p;
   endfunction

   function automatic plan_row_type reg_row(logic [CSR_INDEX_BITS-1:0] index,
                                            logic [CSR_DATA_BITS-1:0] data);
      plan_row_type p;
      p = cmd_row(KIND_ALLOC, '0);
      p.is_write = 1;
      p.index = index;
      p.data = data;
      return p;
   endfunction

   function automatic void check_field(string name, logic [COUNT_BITS-1:0] want,
                                       logic [COUNT_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic settle_results();
      if (expected_results.size() != 0) begin
         start <= 1'b0;
         while (expected_results.size() != 0) @(posedge clock);
      end
   endtask

   task automatic issue_command(bpmq_req_type cmd, int unsigned idle_pct, bit typed = 0,
                                bpmq_rsp_type want = '0);
      int unsigned gap;
      bpmq_rsp_type predicted;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= cmd;
      do @(posedge clock); while (busy);
      predicted = pool_apply_command(cmd);
      expected_results.push_back(typed ? want : predicted);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
      settle_results();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      pool_write_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      bpmq_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result transfer with nothing expected, actual %p", $time, rsp_payload);
            errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", want.status, rsp_payload.status);
            check_field("granted_buffer", want.granted_buffer, rsp_payload.granted_buffer);
            check_field("ready_count", want.ready_count, rsp_payload.ready_count);
            check_field("free_count", want.free_count, rsp_payload.free_count);
            check_field("user_count", want.user_count, rsp_payload.user_count);
            check_field("pool_in_use", want.pool_in_use, rsp_payload.pool_in_use);
            check_field("total_sends", want.total_sends, rsp_payload.total_sends);
            check_field("total_receives", want.total_receives, rsp_payload.total_receives);
            check_field("peak_ready", want.peak_ready, rsp_payload.peak_ready);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("buffer_pool_message_queue_unit: mismatch");
         $finish;
      end
   end

   initial begin
      plan_row_type plan [$];
      logic [CSR_DATA_BITS-1:0] phase_size [PHASES];
      bit phase_growth [PHASES];
      int unsigned idle_table [3];
      int unsigned idle_pct;
      logic [CSR_DATA_BITS-1:0] size_data, growth_data;

      phase_size = '{7'd64, 7'd2, 7'd127, 7'd0, 7'd8, 7'd1, 7'd64, 7'd32};
      phase_growth = '{1, 0, 1, 1, 0, 1, 1, 0};
      idle_table = '{0, 50, 33};
      start_buffers = RESET_BUFFERS;
      growth_on = 1'b0;
      pool_init();

      plan.push_back(cmd_row(KIND_RECV, 6'd0, 1, rsp(STATUS_EMPTY, 0, 0, 16, 0, 16, 0, 0, 0)));
      plan.push_back(cmd_row(KIND_SEND, 6'd63, 1,
                             rsp(STATUS_BAD_BUFFER, 0, 0, 16, 0, 16, 0, 0, 0)));
      plan.push_back(cmd_row(KIND_FREE, 6'd0, 1,
                             rsp(STATUS_BAD_BUFFER, 0, 0, 16, 0, 16, 0, 0, 0)));
      plan.push_back(cmd_row(KIND_PURGE, 6'd0, 1, rsp(STATUS_OK, 0, 0, 16, 0, 16, 0, 0, 0)));
      plan.push_back(cmd_row(KIND_SPARE_TOP, 6'd63, 1,
                             rsp(STATUS_OK, 0, 0, 16, 0, 16, 0, 0, 0)));
      plan.push_back(reg_row(CSR_SPARE, 7'h7F));
      plan.push_back(cmd_row(KIND_ALLOC, 6'd0, 1, rsp(STATUS_OK, 15, 0, 15, 1, 16, 0, 0, 0)));
      plan.push_back(cmd_row(KIND_SEND, 6'd15));
      plan.push_back(cmd_row(KIND_SEND, 6'd15));
      plan.push_back(cmd_row(KIND_ALLOC, 6'd0));
      plan.push_back(cmd_row(KIND_SEND, 6'd14));
      plan.push_back(cmd_row(KIND_RECV, 6'd0));
      plan.push_back(cmd_row(KIND_FREE, 6'd15));
      plan.push_back(cmd_row(KIND_PURGE, 6'd0));
      plan.push_back(cmd_row(KIND_FREE, 6'd14));
      plan.push_back(reg_row(CSR_INITIAL_BUFFERS, 7'd0));
      plan.push_back(reg_row(CSR_ALLOW_GROWTH, 7'd1));
      plan.push_back(cmd_row(KIND_ALLOC, 6'd0, 1, rsp(STATUS_OK, 0, 0, 0, 1, 1, 0, 0, 0)));
      plan.push_back(cmd_row(KIND_ALLOC, 6'd0, 1, rsp(STATUS_NO_FREE, 0, 0, 0, 1, 1, 0, 0, 0)));
      plan.push_back(reg_row(CSR_INITIAL_BUFFERS, 7'd2));
      plan.push_back(cmd_row(KIND_ALLOC, 6'd0, 1, rsp(STATUS_OK, 1, 0, 1, 1, 2, 0, 0, 0)));
      plan.push_back(cmd_row(KIND_ALLOC, 6'd0, 1, rsp(STATUS_OK, 0, 0, 0, 2, 2, 0, 0, 0)));
      plan.push_back(cmd_row(KIND_ALLOC, 6'd0, 1, rsp(STATUS_OK, 2, 0, 0, 3, 3, 0, 0, 0)));
      plan.push_back(reg_row(CSR_INITIAL_BUFFERS, 7'd127));
      plan.push_back(cmd_row(KIND_ALLOC, 6'd0, 1, rsp(STATUS_OK, 63, 0, 63, 1, 64, 0, 0, 0)));
      plan.push_back(cmd_row(KIND_SEND, 6'd63));
      plan.push_back(cmd_row(KIND_SPARE_LOW, 6'd42));
      plan.push_back(cmd_row(KIND_SPARE_MID, 6'd21));
      plan.push_back(cmd_row(KIND_RECV, 6'd0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_write) write_register(plan[i].index, plan[i].data);
         else issue_command(plan[i].cmd, 0, plan[i].typed, plan[i].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         size_data = phase_size[phase];
         if (phase == 4 || phase == 7) size_data = CSR_DATA_BITS'($urandom_range(127));
         growth_data = {CSR_DATA_BITS'($urandom_range(63)) << 1} | phase_growth[phase];
         if ($urandom_range(1)) begin
            write_register(CSR_ALLOW_GROWTH, growth_data);
            write_register(CSR_INITIAL_BUFFERS, size_data);
         end else begin
            write_register(CSR_INITIAL_BUFFERS, size_data);
            write_register(CSR_ALLOW_GROWTH, growth_data);
         end
         idle_pct = idle_table[phase % 3];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            issue_command(random_command(), idle_pct);
            if (i == PHASE_ITEMS / 2 || $urandom_range(99) < 2) settle_results();
         end
      end

      settle_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("buffer_pool_message_queue_unit: match");
      else
         $display("buffer_pool_message_queue_unit: mismatch");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/bpmq_pkg.sv
rtl/bpmq_ram.sv
rtl/buffer_pool_message_queue_unit.sv
test/buffer_pool_message_queue_unit_tb.sv
